@@ design/bpwt_pkg.sv @@
// Shared types, codes and the key ranking function of the bounded priority work table.
package bpwt_pkg;

   localparam int CAPACITY_DEFAULT = 20;

   localparam int COMMAND_W = 2;
   localparam int GRADE_W   = 8;
   localparam int SEQ_W     = 32;
   localparam int STATUS_W  = 3;
   localparam int ENTRY_W   = 5;
   localparam int KEY_W     = GRADE_W + SEQ_W;

   // Distance between first sequence bytes beyond which their order flips
   localparam logic [7:0] WRAP_LIMIT = 8'd10;

   // Command codes
   localparam logic [COMMAND_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [COMMAND_W-1:0] CMD_TAKE   = 2'd1;
   localparam logic [COMMAND_W-1:0] CMD_CLEAR  = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_STORED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_TAKEN    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

   typedef struct packed {
      logic [GRADE_W-1:0] grade;
      logic [SEQ_W-1:0]   seq;
   } key_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;      // capture the accepted request
      logic store_free;    // write the new key at the end of the table
      logic scan_start;    // rewind the scan pointer
      logic scan_step;     // read one entry and rank it next cycle
      logic apply_insert;  // replace the lowest key or drop the new one
      logic read_last;     // read the last entry of the table
      logic move_last;     // move the last entry into the taken slot
      logic set_empty;     // answer a take from an empty table
      logic set_clear;     // empty the table
      logic set_drop;      // answer an unused command
      logic rsp_load;      // move the result into the output register
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_insert;
      logic is_take;
      logic is_clear;
      logic full;
      logic empty;
      logic scan_last;
      logic rsp_free;
   } dp_status_type;

   // True when key a ranks strictly higher than key b
   function automatic logic key_higher(input key_type a, input key_type b);
      logic [7:0] ba;
      logic [7:0] bb;
      logic       higher;
      ba = a.seq[SEQ_W-1 -: 8];
      bb = b.seq[SEQ_W-1 -: 8];
      if (a.grade != b.grade) begin
         higher = (a.grade < b.grade);
      end else if (ba < bb) begin
         higher = ((bb - ba) <= WRAP_LIMIT);
      end else if (ba > bb) begin
         higher = ((ba - bb) > WRAP_LIMIT);
      end else begin
         higher = (a.seq[SEQ_W-9:0] < b.seq[SEQ_W-9:0]);
      end
      return higher;
   endfunction

endpackage

@@ design/bpwt_req_if.sv @@
// Request channel: command and key with valid/ready handshake.
interface bpwt_req_if;
   import bpwt_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [COMMAND_W-1:0] command;
   logic [GRADE_W-1:0]   grade;
   logic [SEQ_W-1:0]     sequence_req;

   modport source (output valid, command, grade, sequence_req, input ready);
   modport sink   (input valid, command, grade, sequence_req, output ready);
endinterface

@@ design/bpwt_rsp_if.sv @@
// Response channel: status, taken key and entry count with valid/ready handshake.
interface bpwt_rsp_if;
   import bpwt_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [GRADE_W-1:0]  out_grade;
   logic [SEQ_W-1:0]    out_sequence;
   logic [ENTRY_W-1:0]  entry_count;

   modport source (output valid, status, out_grade, out_sequence, entry_count, input ready);
   modport sink   (input valid, status, out_grade, out_sequence, entry_count, output ready);
endinterface

@@ design/bpwt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module bpwt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ design/bpwt_ctrl.sv @@
// Controller state machine sequencing insert, take and clear commands.
module bpwt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bpwt_pkg::dp_status_type dp_status,
   output bpwt_pkg::ctrl_cmd_type  ctrl_cmd
);
   import bpwt_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECIDE   = 3'd1;
   localparam logic [2:0] S_SCAN     = 3'd2;
   localparam logic [2:0] S_SCAN_END = 3'd3;
   localparam logic [2:0] S_APPLY    = 3'd4;
   localparam logic [2:0] S_MOVE     = 3'd5;
   localparam logic [2:0] S_RESP     = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      ctrl_cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl_cmd.load_req = 1'b1;
               state_in          = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (dp_status.is_insert && !dp_status.full) begin
               ctrl_cmd.store_free = 1'b1;
               state_in            = S_RESP;
            end else if (dp_status.is_insert ||
                         (dp_status.is_take && !dp_status.empty)) begin
               ctrl_cmd.scan_start = 1'b1;
               state_in            = S_SCAN;
            end else if (dp_status.is_take) begin
               ctrl_cmd.set_empty = 1'b1;
               state_in           = S_RESP;
            end else if (dp_status.is_clear) begin
               ctrl_cmd.set_clear = 1'b1;
               state_in           = S_RESP;
            end else begin
               ctrl_cmd.set_drop = 1'b1;
               state_in          = S_RESP;
            end
         end
         S_SCAN: begin
            ctrl_cmd.scan_step = 1'b1;
            if (dp_status.scan_last) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: begin
            // last entry is ranked in the datapath this cycle
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (dp_status.is_insert) begin
               ctrl_cmd.apply_insert = 1'b1;
               state_in              = S_RESP;
            end else begin
               ctrl_cmd.read_last = 1'b1;
               state_in           = S_MOVE;
            end
         end
         S_MOVE: begin
            ctrl_cmd.move_last = 1'b1;
            state_in           = S_RESP;
         end
         S_RESP: begin
            if (dp_status.rsp_free) begin
               ctrl_cmd.rsp_load = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

@@ design/bpwt_dp.sv @@
// Datapath: key table memory, entry count, ranking scan and output register.
module bpwt_dp #(
   parameter int CAPACITY = bpwt_pkg::CAPACITY_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [bpwt_pkg::COMMAND_W-1:0]      req_command,
   input  logic [bpwt_pkg::GRADE_W-1:0]        req_grade,
   input  logic [bpwt_pkg::SEQ_W-1:0]          req_sequence,
   input  bpwt_pkg::ctrl_cmd_type              ctrl_cmd,
   output bpwt_pkg::dp_status_type             dp_status,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bpwt_pkg::STATUS_W-1:0]       rsp_status,
   output logic [bpwt_pkg::GRADE_W-1:0]        rsp_grade,
   output logic [bpwt_pkg::SEQ_W-1:0]          rsp_sequence,
   output logic [bpwt_pkg::ENTRY_W-1:0]        rsp_count
);
   import bpwt_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic [COMMAND_W-1:0] cmd_ff;
   key_type              new_key_ff;
   logic [CW-1:0]        count_ff,      count_in;
   logic [AW-1:0]        scan_idx_ff,   scan_idx_in;
   logic                 cmp_vld_ff;
   logic [AW-1:0]        cmp_idx_ff;
   key_type              best_key_ff,   best_key_in;
   logic [AW-1:0]        best_idx_ff,   best_idx_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   key_type              res_key_ff,    res_key_in;
   logic                 rsp_vld_ff,    rsp_vld_in;
   logic [STATUS_W-1:0]  rsp_status_ff;
   key_type              rsp_key_ff;
   logic [ENTRY_W-1:0]   rsp_count_ff;

   logic [CW-1:0]        count_dec;
   logic [AW-1:0]        last_idx;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   key_type              wr_data;
   logic [AW-1:0]        rd_addr;
   logic [KEY_W-1:0]     rd_raw;
   key_type              rd_key;

   assign count_dec = count_ff - CW'(1);
   assign last_idx  = count_dec[AW-1:0];
   assign rd_key    = key_type'(rd_raw);

   // Status toward the controller
   assign dp_status.is_insert = (cmd_ff == CMD_INSERT);
   assign dp_status.is_take   = (cmd_ff == CMD_TAKE);
   assign dp_status.is_clear  = (cmd_ff == CMD_CLEAR);
   assign dp_status.full      = (count_ff == CW'(CAPACITY));
   assign dp_status.empty     = (count_ff == '0);
   assign dp_status.scan_last = (scan_idx_ff == last_idx);
   assign dp_status.rsp_free  = !rsp_vld_ff || rsp_ready;

   // Key table
   bpwt_ram #(
      .WIDTH (KEY_W),
      .DEPTH (CAPACITY)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   // Memory port selection
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = best_idx_ff;
      wr_data = rd_key;
      rd_addr = ctrl_cmd.read_last ? last_idx : scan_idx_ff;
      if (ctrl_cmd.store_free) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[AW-1:0];
         wr_data = new_key_ff;
      end else if (ctrl_cmd.apply_insert) begin
         wr_en   = key_higher(new_key_ff, best_key_ff);
         wr_data = new_key_ff;
      end else if (ctrl_cmd.move_last) begin
         wr_en = 1'b1;
      end
   end

   // Scan pointer, running best entry, count and result
   always_comb begin
      count_in      = count_ff;
      scan_idx_in   = scan_idx_ff;
      best_key_in   = best_key_ff;
      best_idx_in   = best_idx_ff;
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;

      if (ctrl_cmd.scan_start) begin
         scan_idx_in = '0;
      end else if (ctrl_cmd.scan_step) begin
         scan_idx_in = scan_idx_ff + AW'(1);
      end

      // rank the entry read last cycle; ties keep the earlier slot
      if (cmp_vld_ff) begin
         if (cmp_idx_ff == '0) begin
            best_key_in = rd_key;
            best_idx_in = cmp_idx_ff;
         end else if (dp_status.is_take ? key_higher(rd_key, best_key_ff)
                                        : key_higher(best_key_ff, rd_key)) begin
            best_key_in = rd_key;
            best_idx_in = cmp_idx_ff;
         end
      end

      if (ctrl_cmd.store_free) begin
         count_in      = count_ff + CW'(1);
         res_status_in = ST_STORED;
         res_key_in    = '0;
      end else if (ctrl_cmd.apply_insert) begin
         res_status_in = key_higher(new_key_ff, best_key_ff) ? ST_REPLACED : ST_DROPPED;
         res_key_in    = '0;
      end else if (ctrl_cmd.move_last) begin
         count_in      = count_dec;
         res_status_in = ST_TAKEN;
         res_key_in    = best_key_ff;
      end else if (ctrl_cmd.set_empty) begin
         res_status_in = ST_EMPTY;
         res_key_in    = '0;
      end else if (ctrl_cmd.set_clear) begin
         count_in      = '0;
         res_status_in = ST_CLEARED;
         res_key_in    = '0;
      end else if (ctrl_cmd.set_drop) begin
         res_status_in = ST_DROPPED;
         res_key_in    = '0;
      end
   end

   // Output register valid: set on load, drop after the transfer
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (ctrl_cmd.rsp_load) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         cmp_vld_ff <= ctrl_cmd.scan_step;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (ctrl_cmd.load_req) begin
         cmd_ff           <= req_command;
         new_key_ff.grade <= req_grade;
         new_key_ff.seq   <= req_sequence;
      end
      scan_idx_ff   <= scan_idx_in;
      cmp_idx_ff    <= scan_idx_ff;
      best_key_ff   <= best_key_in;
      best_idx_ff   <= best_idx_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      if (ctrl_cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_key_ff    <= res_key_ff;
         rsp_count_ff  <= ENTRY_W'(count_ff);
      end
   end

   assign rsp_valid    = rsp_vld_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_grade    = rsp_key_ff.grade;
   assign rsp_sequence = rsp_key_ff.seq;
   assign rsp_count    = rsp_count_ff;
endmodule

@@ design/bounded_priority_work_table.sv @@
// Top level of the bounded priority work table: controller, datapath and channels.
//
//   channel  | dir | payload                                        | transfer
//   ---------+-----+------------------------------------------------+------------------
//   req_ch   | in  | command, grade, sequence_req                   | valid & ready
//   rsp_ch   | out | status, out_grade, out_sequence, entry_count   | valid & ready
//
// One command is in work at a time. Insert into a free slot, clear and take from an
// empty table go from the decide state straight to the response state. Insert into a
// full table and take first scan every held entry: the single read port of the key
// table ranks one entry per cycle. The result sits in an output register, so a new
// request transfers while it waits. Synchronous reset empties the table at once.
module bounded_priority_work_table #(
   parameter int CAPACITY = bpwt_pkg::CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   bpwt_req_if.sink    req_ch,
   bpwt_rsp_if.source  rsp_ch
);
   import bpwt_pkg::*;

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   bpwt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .dp_status (dp_status),
      .ctrl_cmd  (ctrl_cmd)
   );

   bpwt_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_command  (req_ch.command),
      .req_grade    (req_ch.grade),
      .req_sequence (req_ch.sequence_req),
      .ctrl_cmd     (ctrl_cmd),
      .dp_status    (dp_status),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .rsp_status   (rsp_ch.status),
      .rsp_grade    (rsp_ch.out_grade),
      .rsp_sequence (rsp_ch.out_sequence),
      .rsp_count    (rsp_ch.entry_count)
   );
endmodule

@@ design/bpwt_checker.sv @@
// Port-level assertions for the bounded priority work table and their bind.
module bpwt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bpwt_pkg::STATUS_W-1:0] rsp_status,
   input logic [bpwt_pkg::GRADE_W-1:0]  rsp_grade,
   input logic [bpwt_pkg::SEQ_W-1:0]    rsp_sequence,
   input logic [bpwt_pkg::ENTRY_W-1:0]  rsp_count
);
   import bpwt_pkg::*;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_grade) && $stable(rsp_sequence) && $stable(rsp_count))
      else $error("stalled response changed");

   // One command at a time: ready drops after a request transfer
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a command is in work");

   // Only a take returns a key
   a_key_only_taken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_TAKEN |-> rsp_grade == '0 && rsp_sequence == '0)
      else $error("key returned without a take");

   // Clear and empty take leave no entries
   a_count_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_CLEARED || rsp_status == ST_EMPTY) |->
      rsp_count == '0)
      else $error("entry count not zero after clear or empty take");
endmodule

bind bounded_priority_work_table bpwt_checker u_bpwt_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_status   (rsp_ch.status),
   .rsp_grade    (rsp_ch.out_grade),
   .rsp_sequence (rsp_ch.out_sequence),
   .rsp_count    (rsp_ch.entry_count)
);
